FILE: hdl/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int MAP_WORDS     = 64;
    localparam int BITS_PER_WORD = 64;
    localparam int WORD_AW       = $clog2(MAP_WORDS);
    localparam int BIT_AW        = $clog2(BITS_PER_WORD);
    localparam int CNT_W         = 7;
    localparam int SLOT_W        = 12;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_USE   = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_RMW
    } t_state;

    typedef struct packed {
        logic               found;
        logic [WORD_AW-1:0] word;
    } t_srch;

    typedef struct packed {
        logic [1:0]         mode;
        logic [WORD_AW-1:0] word;
        logic [BIT_AW-1:0]  bit_idx;
        logic               do_write;
        t_status            status;
    } t_op;

    // Index of the lowest set bit, zero when no bit is set.
    function automatic logic [BIT_AW-1:0] f_lowest(input logic [BITS_PER_WORD-1:0] v);
        logic [BIT_AW-1:0] idx;
        idx = '0;
        for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_AW'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: hdl/bsa_map_mem.sv
`timescale 1ns / 1ps

module bsa_map_mem (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_rd_en,
    input  logic [bsa_pkg::WORD_AW-1:0]          i_rd_addr,
    output logic [bsa_pkg::BITS_PER_WORD-1:0]    o_rd_data,
    input  logic                                 i_wr_en,
    input  logic [bsa_pkg::WORD_AW-1:0]          i_wr_addr,
    input  logic [bsa_pkg::BITS_PER_WORD-1:0]    i_wr_data
);

    logic [bsa_pkg::BITS_PER_WORD-1:0] r_mem [bsa_pkg::MAP_WORDS];
    logic [bsa_pkg::BITS_PER_WORD-1:0] r_rd_q;
    logic [bsa_pkg::MAP_WORDS-1:0]     r_written;
    logic                              r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    // A word never written since reset reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_q : {bsa_pkg::BITS_PER_WORD{1'b1}};

endmodule

FILE: hdl/bsa_search.sv
`timescale 1ns / 1ps

module bsa_search (
    input  logic [bsa_pkg::MAP_WORDS-1:0] i_nonempty,
    input  logic [bsa_pkg::CNT_W-1:0]     i_n_eff,
    input  logic [bsa_pkg::WORD_AW-1:0]   i_start,
    output bsa_pkg::t_srch                o_srch
);

    logic [bsa_pkg::MAP_WORDS-1:0] in_use;
    logic [bsa_pkg::MAP_WORDS-1:0] cand;
    logic [bsa_pkg::MAP_WORDS-1:0] upper;

    always_comb begin
        for (int i = 0; i < bsa_pkg::MAP_WORDS; i++) begin
            in_use[i] = (bsa_pkg::CNT_W'(i) < i_n_eff);
        end
        cand  = i_nonempty & in_use;
        upper = cand & ({bsa_pkg::MAP_WORDS{1'b1}} << i_start);
        o_srch.found = |cand;
        // Words at or above the start come first, then the search wraps.
        if (|upper) begin
            o_srch.word = bsa_pkg::f_lowest(upper);
        end else begin
            o_srch.word = bsa_pkg::f_lowest(cand);
        end
    end

endmodule

FILE: hdl/bsa_rem.sv
`timescale 1ns / 1ps

module bsa_rem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [bsa_pkg::WORD_AW-1:0]    i_hint,
    input  logic [bsa_pkg::CNT_W-1:0]      i_div,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [bsa_pkg::WORD_AW-1:0]    o_rem
);

    localparam int CW = $clog2(bsa_pkg::WORD_AW);

    logic                         r_busy;
    logic [CW-1:0]                r_cnt;
    logic [bsa_pkg::WORD_AW-1:0]  r_rem;
    logic [bsa_pkg::WORD_AW-1:0]  r_hint;
    logic [bsa_pkg::CNT_W-1:0]    r_div;
    logic [bsa_pkg::CNT_W-1:0]    trial;
    logic [bsa_pkg::CNT_W-1:0]    res;

    // Restoring remainder, one hint bit per cycle, most significant first.
    always_comb begin
        trial = {r_rem, r_hint[r_cnt]};
        res   = (trial >= r_div) ? trial - r_div : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(bsa_pkg::WORD_AW - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_hint <= i_hint;
            r_div  <= i_div;
        end else if (r_busy) begin
            r_rem <= res[bsa_pkg::WORD_AW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == '0);
    assign o_rem  = res[bsa_pkg::WORD_AW-1:0];

endmodule

FILE: hdl/bitmap_slot_allocator_core.sv
`timescale 1ns / 1ps

// Bitmap slot allocator: 64 map words of 64 slots, a set bit marks a free slot.
// Each item is accepted in ST_IDLE, which picks the word (from the per-word
// nonempty flags through a rotating priority encoder for an allocate, from the
// slot index otherwise) and issues the map memory read; ST_RMW then, once the
// output register is free, modifies the word and writes it back through the
// memory's write port. A result may wait on a stalled output while the next
// item is accepted; the write-back of that item then waits until the output
// register is free. Writing a nonzero words_in_use stalls the input while the
// search start is reduced modulo the new word count, one hint bit per cycle.

module bitmap_slot_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_slot_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_granted_slot,
    output logic [1:0]  o_status
);

    localparam int AW = bsa_pkg::WORD_AW;
    localparam int BW = bsa_pkg::BIT_AW;
    localparam int NW = bsa_pkg::CNT_W;
    localparam int DW = bsa_pkg::BITS_PER_WORD;

    bsa_pkg::t_state r_state;
    bsa_pkg::t_state n_state;
    bsa_pkg::t_op    r_op;
    bsa_pkg::t_op    n_op;
    bsa_pkg::t_srch  srch;

    logic [NW-1:0]                 r_n_eff;
    logic [AW-1:0]                 r_hint;
    logic [AW-1:0]                 r_start;
    logic [bsa_pkg::MAP_WORDS-1:0] r_nz;
    logic                          r_out_valid;
    logic [11:0]                   r_granted;
    bsa_pkg::t_status              r_status;

    logic [NW-1:0] cfg_n;
    logic          rem_busy;
    logic          rem_done;
    logic [AW-1:0] rem_val;
    logic          accept;
    logic          out_free;
    logic          finish;
    logic          rd_en;
    logic          wr_en;
    logic [DW-1:0] rd_data;
    logic [DW-1:0] wr_data;
    logic [BW-1:0] low_bit;
    logic          new_nz;
    logic          upd_hint;

    assign cfg_n = (i_cfg_wdata > NW'(bsa_pkg::MAP_WORDS)) ?
                   NW'(bsa_pkg::MAP_WORDS) : i_cfg_wdata;

    bsa_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we && (cfg_n != '0)),
        .i_hint  (r_hint),
        .i_div   (cfg_n),
        .o_busy  (rem_busy),
        .o_done  (rem_done),
        .o_rem   (rem_val)
    );

    bsa_search u_search (
        .i_nonempty (r_nz),
        .i_n_eff    (r_n_eff),
        .i_start    (r_start),
        .o_srch     (srch)
    );

    bsa_map_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (n_op.word),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_op.word),
        .i_wr_data (wr_data)
    );

    assign o_in_stall = (r_state != bsa_pkg::ST_IDLE) || rem_busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Decode of the incoming item.
    always_comb begin
        n_op.mode     = i_mode;
        n_op.word     = i_slot_index[11:BW];
        n_op.bit_idx  = i_slot_index[BW-1:0];
        n_op.do_write = 1'b0;
        n_op.status   = bsa_pkg::STAT_OK;
        case (i_mode)
            bsa_pkg::MODE_ALLOC: begin
                n_op.word = srch.word;
                if (srch.found) begin
                    n_op.do_write = 1'b1;
                end else begin
                    n_op.status = bsa_pkg::STAT_FULL;
                end
            end
            bsa_pkg::MODE_FREE, bsa_pkg::MODE_USE: begin
                if ({1'b0, i_slot_index[11:BW]} >= r_n_eff) begin
                    n_op.status = bsa_pkg::STAT_RANGE;
                end else begin
                    n_op.do_write = 1'b1;
                end
            end
            default: begin
                n_op.do_write = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsa_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = bsa_pkg::ST_RMW;
                end
            end
            bsa_pkg::ST_RMW: begin
                if (out_free) begin
                    n_state = bsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bsa_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs and the modify step.
    always_comb begin
        rd_en    = 1'b0;
        finish   = 1'b0;
        case (r_state)
            bsa_pkg::ST_IDLE: begin
                rd_en = accept && n_op.do_write;
            end
            bsa_pkg::ST_RMW: begin
                finish = out_free;
            end
            default: begin
                finish = 1'b0;
            end
        endcase

        low_bit = bsa_pkg::f_lowest(rd_data);
        case (r_op.mode)
            bsa_pkg::MODE_ALLOC: wr_data = rd_data & ~(DW'(1) << low_bit);
            bsa_pkg::MODE_FREE:  wr_data = rd_data | (DW'(1) << r_op.bit_idx);
            default:             wr_data = rd_data & ~(DW'(1) << r_op.bit_idx);
        endcase
        new_nz   = |wr_data;
        wr_en    = finish && r_op.do_write;
        // An allocate leaves the hint alone when it empties the word.
        upd_hint = wr_en && ((r_op.mode != bsa_pkg::MODE_ALLOC) || new_nz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsa_pkg::ST_IDLE;
            r_n_eff     <= NW'(bsa_pkg::MAP_WORDS);
            r_hint      <= '0;
            r_start     <= '0;
            r_nz        <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_n_eff <= cfg_n;
            end
            if (rem_done) begin
                r_start <= rem_val;
            end
            if (upd_hint) begin
                r_hint  <= r_op.word;
                r_start <= r_op.word;
            end
            if (wr_en) begin
                r_nz[r_op.word] <= new_nz;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
        if (finish) begin
            r_status  <= r_op.status;
            if (wr_en && (r_op.mode == bsa_pkg::MODE_ALLOC)) begin
                r_granted <= {r_op.word, low_bit};
            end else begin
                r_granted <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_granted_slot = r_granted;
    assign o_status       = r_status;

    a_accept_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_state == bsa_pkg::ST_IDLE))
        else $error("item accepted while an item is in flight");

    a_start_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!rem_busy && (r_n_eff != '0)) |-> ({1'b0, r_start} < r_n_eff))
        else $error("search start beyond the words in use");

    a_grant_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_granted_slot != '0)) |-> (o_status == bsa_pkg::STAT_OK))
        else $error("granted slot reported with a failure status");

    a_finish_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> o_out_valid)
        else $error("finished item did not reach the output register");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bsa_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_CONFIG,
        OP_DRAIN
    } op_kind_t;

    typedef struct {
        op_kind_t          kind;
        logic [1:0]        mode;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  words;
    } pending_op_t;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } slot_result_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [6:0]        i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_mode = MODE_ALLOC;
    logic [11:0]       i_slot_index = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [11:0]       o_granted_slot;
    logic [1:0]        o_status;

    // Our own copy of the allocator state.
    logic [BITS_PER_WORD-1:0] free_words[MAP_WORDS];
    logic [WORD_AW-1:0]       hint_word;
    logic [CNT_W-1:0]         words_setting;

    pending_op_t  pending_ops[$];
    slot_result_t slot_results_q[$];
    logic         in_taken = 1'b0;
    int           error_count = 0;
    int           burst_left = 1;
    int           gap_left = 0;
    int           quiet_cycles = 0;
    int           stall_stretch = 0;
    int           stall_style = 0;
    logic [31:0]  stall_pattern = '0;

    bitmap_slot_allocator_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_slot_index   (i_slot_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_granted_slot (o_granted_slot),
        .o_status       (o_status)
    );

    always #6 i_clk = ~i_clk;

    function automatic slot_result_t predict_slot_result(input logic [1:0] mode,
                                                         input logic [SLOT_W-1:0] slot);
        slot_result_t r;
        int n;
        int start;
        int w;
        int b;
        logic found;
        r.slot = '0;
        r.status = STAT_OK;
        found = 1'b0;
        n = (words_setting > MAP_WORDS) ? MAP_WORDS : int'(words_setting);
        if (mode == MODE_ALLOC) begin
            r.status = STAT_FULL;
            if (n != 0) begin
                start = int'(hint_word) % n;
                for (int i = 0; i < n; i++) begin
                    w = (start + i) % n;
                    if (!found && free_words[w] != '0) begin
                        found = 1'b1;
                        b = 0;
                        for (int k = BITS_PER_WORD - 1; k >= 0; k--) begin
                            if (free_words[w][k]) begin
                                b = k;
                            end
                        end
                        free_words[w][b] = 1'b0;
                        // The hint only follows a word that still has room.
                        if (free_words[w] != '0) begin
                            hint_word = WORD_AW'(w);
                        end
                        r.slot = SLOT_W'(w * BITS_PER_WORD + b);
                        r.status = STAT_OK;
                    end
                end
            end
        end else if (mode == MODE_FREE || mode == MODE_USE) begin
            w = int'(slot) / BITS_PER_WORD;
            b = int'(slot) % BITS_PER_WORD;
            if (w >= n) begin
                r.status = STAT_RANGE;
            end else begin
                free_words[w][b] = (mode == MODE_FREE);
                hint_word = WORD_AW'(w);
            end
        end
        return r;
    endfunction

    task automatic add_item(input logic [1:0] mode, input logic [SLOT_W-1:0] slot);
        pending_op_t op;
        op.kind = OP_ITEM;
        op.mode = mode;
        op.slot = slot;
        op.words = '0;
        pending_ops.push_back(op);
    endtask

    task automatic add_config(input logic [CNT_W-1:0] words);
        pending_op_t op;
        op.kind = OP_CONFIG;
        op.mode = MODE_ALLOC;
        op.slot = '0;
        op.words = words;
        pending_ops.push_back(op);
    endtask

    task automatic add_drain();
        pending_op_t op;
        op.kind = OP_DRAIN;
        op.mode = MODE_ALLOC;
        op.slot = '0;
        op.words = '0;
        pending_ops.push_back(op);
    endtask

    // Allocs at alloc_pct percent, else in-range frees and marks; a few wild indexes.
    task automatic random_phase(input logic [CNT_W-1:0] words, input int count,
                                input int alloc_pct);
        int n;
        int pick;
        logic [SLOT_W-1:0] slot;
        n = (words > MAP_WORDS) ? MAP_WORDS : int'(words);
        add_config(words);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (n != 0 && $urandom_range(9) != 0) begin
                slot = SLOT_W'($urandom_range(n * BITS_PER_WORD - 1));
            end else begin
                slot = SLOT_W'($urandom_range(4095));
            end
            if (pick < alloc_pct) begin
                add_item(MODE_ALLOC, SLOT_W'($urandom_range(4095)));
            end else if (pick < 97) begin
                add_item(($urandom_range(1) != 0) ? MODE_FREE : MODE_USE, slot);
            end else begin
                add_item(MODE_NONE, slot);
            end
            if ($urandom_range(59) == 0) begin
                add_drain();
            end
        end
    endtask

    // Sender and receiver both change on the falling edge.
    always @(negedge i_clk) begin
        pending_op_t      op;
        logic             busy;
        logic             valid_next;
        logic [1:0]       mode_next;
        logic [SLOT_W-1:0] slot_next;
        logic             cfg_next;
        logic [CNT_W-1:0] cfg_data_next;
        logic             stall_next;
        valid_next = i_in_valid;
        mode_next = i_mode;
        slot_next = i_slot_index;
        cfg_next = 1'b0;
        cfg_data_next = i_cfg_wdata;
        stall_next = 1'b0;
        if (i_rst_n) begin
            if (stall_stretch == 0) begin
                stall_stretch = $urandom_range(300, 40);
                stall_style = $urandom_range(2);
                stall_pattern = $urandom;
            end
            stall_stretch--;
            case (stall_style)
                1: begin
                    stall_next = ($urandom_range(99) < 35);
                end
                2: begin
                    stall_next = stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
                end
                default: begin
                    stall_next = 1'b0;
                end
            endcase

            busy = i_in_valid && !in_taken;
            if (!busy) begin
                valid_next = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ops.size() != 0) begin
                    op = pending_ops[0];
                    case (op.kind)
                        OP_ITEM: begin
                            void'(pending_ops.pop_front());
                            valid_next = 1'b1;
                            mode_next = op.mode;
                            slot_next = op.slot;
                            if (burst_left > 1) begin
                                burst_left--;
                            end else begin
                                burst_left = $urandom_range(24, 1);
                                gap_left = ($urandom_range(9) < 4) ? 0 : $urandom_range(8, 1);
                            end
                        end
                        OP_CONFIG: begin
                            // The register is only touched once the block has gone quiet.
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                void'(pending_ops.pop_front());
                                cfg_next = 1'b1;
                                cfg_data_next = op.words;
                            end
                        end
                        default: begin
                            if (slot_results_q.size() == 0) begin
                                void'(pending_ops.pop_front());
                            end
                        end
                    endcase
                end
            end

            if (slot_results_q.size() == 0 && !valid_next && !cfg_next && !i_cfg_we) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
        end
        i_in_valid <= valid_next;
        i_mode <= mode_next;
        i_slot_index <= slot_next;
        i_cfg_we <= cfg_next;
        i_cfg_wdata <= cfg_data_next;
        i_out_stall <= stall_next;
    end

    // Prediction on accepted items, checking on accepted results.
    always @(posedge i_clk) begin
        slot_result_t exp_r;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_cfg_we) begin
                words_setting = i_cfg_wdata;
            end
            if (o_out_valid && !i_out_stall) begin
                if (slot_results_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("ERROR: unexpected item: slot %0d status %0d",
                                 o_granted_slot, o_status);
                    end
                end else begin
                    exp_r = slot_results_q.pop_front();
                    if (o_granted_slot !== exp_r.slot || o_status !== exp_r.status) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("ERROR: expected slot %0d status %0d, got slot %0d status %0d",
                                     exp_r.slot, exp_r.status, o_granted_slot, o_status);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                slot_results_q.push_back(predict_slot_result(i_mode, i_slot_index));
            end
        end
    end

    initial begin
        int cycles;
        for (int i = 0; i < MAP_WORDS; i++) begin
            free_words[i] = '1;
        end
        hint_word = '0;
        words_setting = 7'd64;

        // Directed opening: basic allocation, frees, marks, range and full checks.
        add_item(MODE_ALLOC, 12'd0);
        add_item(MODE_ALLOC, 12'd4095);
        add_item(MODE_FREE, 12'd0);
        add_item(MODE_ALLOC, 12'd0);
        add_item(MODE_USE, 12'd4095);
        add_item(MODE_FREE, 12'd4095);
        add_item(MODE_NONE, 12'd4095);
        add_item(MODE_NONE, 12'd0);
        add_item(MODE_FREE, 12'd100);
        add_item(MODE_USE, 12'd1);
        add_item(MODE_USE, 12'd2600);
        add_drain();
        // Hint now sits past the new word count.
        add_config(7'd5);
        add_item(MODE_ALLOC, 12'd0);
        add_item(MODE_FREE, 12'd320);
        add_item(MODE_FREE, 12'd319);
        add_config(7'd1);
        add_item(MODE_USE, 12'd64);
        add_item(MODE_ALLOC, 12'd0);
        add_config(7'd0);
        add_item(MODE_ALLOC, 12'd0);
        add_item(MODE_FREE, 12'd0);
        add_item(MODE_USE, 12'd0);
        add_config(7'd127);
        add_item(MODE_ALLOC, 12'd0);
        add_item(MODE_USE, 12'd4095);
        add_config(7'd100);
        add_item(MODE_ALLOC, 12'd0);

        // Small word counts with heavy allocation run the map full; others vary the count.
        random_phase(7'd1, 90, 85);
        random_phase(7'd2, 80, 80);
        random_phase(7'd64, 80, 50);
        random_phase(7'd3, 80, 75);
        random_phase(7'd0, 40, 40);
        random_phase(7'd13, 80, 60);
        random_phase(7'd127, 80, 55);
        random_phase(7'd1, 80, 70);
        random_phase(7'd40, 80, 55);
        random_phase(7'd64, 80, 50);
        random_phase(7'd7, 80, 80);
        random_phase(7'd65, 60, 50);
        random_phase(7'd1, 40, 60);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        cycles = 0;
        while ((pending_ops.size() != 0 || i_in_valid || slot_results_q.size() != 0)
               && cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
        end else begin
            repeat (20) @(posedge i_clk);
            if (error_count == 0 && slot_results_q.size() == 0) begin
                $display("Test completed successfully");
            end else begin
                $display("Test completed with failures");
            end
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/bsa_pkg.sv
hdl/bsa_map_mem.sv
hdl/bsa_search.sv
hdl/bsa_rem.sv
hdl/bitmap_slot_allocator_core.sv
tb/sv/testbench.sv
